### src/jcrbs_pkg.sv
// Shared types and constants of the jump, call and return bus sequencer.
`default_nettype none

package jcrbs_pkg;

    // Input word layout
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 1;
    // Result word layout
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    // Result queue: room for the widest burst (three words) plus one waiting word
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned MAX_BURST  = 3;
    localparam int unsigned BURST_W    = $clog2(MAX_BURST + 1);

    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] STATUS_B5  = 8'h20;

    localparam logic [2:0] PH_IDLE = 3'd0;

    // Input word type carried on s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_RDATA = 1'b1;

    typedef enum logic [2:0] {
        INS_JMP_ABS = 3'd0,
        INS_JMP_IND = 3'd1,
        INS_CALL    = 3'd2,
        INS_RTI     = 3'd3,
        INS_RTS     = 3'd4
    } instr_e;

    typedef enum logic [1:0] {
        RES_READ  = 2'd0,
        RES_WRITE = 2'd1,
        RES_DONE  = 2'd2
    } res_kind_e;

    typedef struct packed {
        res_kind_e   kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [15:0] pc;
        logic [7:0]  sp;
        logic [7:0]  status;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

### src/jump_call_return_bus_sequencer.sv
// Top level: control-flow instruction bus sequencer with its result queue.
//
// Usage
//   s_ side: one input word per bus cycle response. s_tuser = 0 starts an
//   instruction (kind, PC after the opcode, SP, status in s_tdata); s_tuser = 1
//   returns the byte for the last read request. Read data while idle is dropped.
//   A start while an instruction is in progress abandons it.
//   m_ side: result words. m_tuser gives read request, write or done;
//   m_tdata carries the bus address, write byte and, on done, the new PC,
//   SP and status. m_tlast marks the last word caused by one input word.
// Timing and throughput
//   Each input word is decoded in the accept cycle and its results land in
//   the result queue in the cycle after. One input word per cycle is sustained
//   while the receiver takes one word per cycle; the second read of a call
//   produces three words (two pushes and the operand read), which the
//   receiver drains one at a time. s_tready drops only when the four-entry
//   queue could not take a full three-word burst.
// Reset
//   aresetn (synchronous, active low) empties the queue and returns to idle
//   with PC, SP, status and scratch bytes cleared.
// Receiver stall
//   Words hold in the queue; the input side keeps accepting while at most one
//   word is waiting, so a finished result does not block the next input.
`default_nettype none

module jump_call_return_bus_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // instruction[2:0], pc_in[18:3], sp_in[26:19], status_in[34:27],
    // read_data[42:35], zero fill [47:43]
    input  wire logic [jcrbs_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  wire logic [jcrbs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // bus_address[15:0], write_data[23:16], new_pc[39:24], new_sp[47:40],
    // new_status[55:48]
    output logic [jcrbs_pkg::M_TDATA_W-1:0]      m_tdata,
    // result_kind[1:0]
    output logic [jcrbs_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tlast
);
    import jcrbs_pkg::*;

    // Sequencer state
    logic [2:0]  phase_reg, phase_next;
    instr_e      kind_reg, kind_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  sp_reg, sp_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] ptr_reg, ptr_next;

    // Result queue
    result_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    // Decoded input word
    logic        in_op;
    instr_e      in_instr;
    logic [15:0] in_pc;
    logic [7:0]  in_sp;
    logic [7:0]  in_status;
    logic [7:0]  in_rdata;

    logic        s_accept, m_accept;
    result_t     res [MAX_BURST];
    logic [BURST_W-1:0] n_res;
    logic [BURST_W-1:0] n_push;
    logic [7:0]  sp_m1;
    logic [7:0]  sp_p1;
    logic [15:0] pc_p1;

    assign in_op     = s_tuser[0];
    assign in_instr  = instr_e'(s_tdata[2:0]);
    assign in_pc     = s_tdata[18:3];
    assign in_sp     = s_tdata[26:19];
    assign in_status = s_tdata[34:27];
    assign in_rdata  = s_tdata[42:35];

    assign sp_m1 = sp_reg - 8'd1;
    assign sp_p1 = sp_reg + 8'd1;
    assign pc_p1 = pc_reg + 16'd1;

    // Take a word only if a three-word burst still fits after this cycle's pop
    assign s_tready = (count_reg <= FIFO_CNT_W'(1))
                   || ((count_reg == FIFO_CNT_W'(2)) && m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    assign m_tdata = {fifo_reg[rd_ptr_reg].status, fifo_reg[rd_ptr_reg].sp,
                      fifo_reg[rd_ptr_reg].pc, fifo_reg[rd_ptr_reg].wdata,
                      fifo_reg[rd_ptr_reg].addr};
    assign m_tuser = fifo_reg[rd_ptr_reg].kind;
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

    // One pass over the accepted word: next state and up to three results
    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        low_next    = low_reg;
        ptr_next    = ptr_reg;
        n_res       = '0;
        for (int i = 0; i < MAX_BURST; i++) begin
            res[i] = '{kind: RES_READ, addr: '0, wdata: '0, pc: '0, sp: '0,
                       status: '0, last: 1'b0};
        end

        if (in_op == OP_START) begin
            kind_next   = in_instr;
            pc_next     = in_pc;
            sp_next     = in_sp;
            status_next = in_status;
            n_res       = BURST_W'(1);
            if (in_instr > INS_RTS) begin
                // Unknown code: report unchanged state, stay idle
                phase_next    = PH_IDLE;
                res[0].kind   = RES_DONE;
                res[0].pc     = in_pc;
                res[0].sp     = in_sp;
                res[0].status = in_status;
            end else begin
                phase_next  = 3'd1;
                res[0].addr = in_pc;
                if (in_instr <= INS_CALL) begin
                    pc_next = in_pc + 16'd1;
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            phase_next = phase_reg + 3'd1;
            n_res      = BURST_W'(1);
            case (kind_reg)
                INS_JMP_ABS: begin
                    if (phase_reg == 3'd1) begin
                        low_next    = in_rdata;
                        res[0].addr = pc_reg;
                        pc_next     = pc_p1;
                    end else begin
                        pc_next = {in_rdata, low_reg};
                        phase_next = PH_IDLE;
                        res[0].kind = RES_DONE;
                    end
                end
                INS_JMP_IND: begin
                    if (phase_reg == 3'd1) begin
                        low_next    = in_rdata;
                        res[0].addr = pc_reg;
                        pc_next     = pc_p1;
                    end else if (phase_reg == 3'd2) begin
                        ptr_next    = {in_rdata, low_reg};
                        res[0].addr = {in_rdata, low_reg};
                    end else if (phase_reg == 3'd3) begin
                        // High byte comes from the same page: no carry
                        low_next    = in_rdata;
                        res[0].addr = {ptr_reg[15:8], ptr_reg[7:0] + 8'd1};
                    end else begin
                        pc_next = {in_rdata, low_reg};
                        phase_next = PH_IDLE;
                        res[0].kind = RES_DONE;
                    end
                end
                INS_CALL: begin
                    if (phase_reg == 3'd1) begin
                        low_next    = in_rdata;
                        res[0].addr = {STACK_PAGE, sp_reg};
                    end else if (phase_reg == 3'd2) begin
                        // Push return address high then low, then fetch operand high
                        n_res        = BURST_W'(3);
                        res[0].kind  = RES_WRITE;
                        res[0].addr  = {STACK_PAGE, sp_reg};
                        res[0].wdata = pc_reg[15:8];
                        res[1].kind  = RES_WRITE;
                        res[1].addr  = {STACK_PAGE, sp_m1};
                        res[1].wdata = pc_reg[7:0];
                        res[2].addr  = pc_reg;
                        sp_next      = sp_reg - 8'd2;
                        pc_next      = pc_p1;
                    end else begin
                        pc_next = {in_rdata, low_reg};
                        phase_next = PH_IDLE;
                        res[0].kind = RES_DONE;
                    end
                end
                INS_RTI: begin
                    if (phase_reg == 3'd1) begin
                        res[0].addr = {STACK_PAGE, sp_reg};
                        sp_next     = sp_p1;
                    end else if (phase_reg == 3'd2) begin
                        res[0].addr = {STACK_PAGE, sp_reg};
                    end else if (phase_reg == 3'd3) begin
                        status_next = in_rdata | STATUS_B5;
                        sp_next     = sp_p1;
                        res[0].addr = {STACK_PAGE, sp_p1};
                    end else if (phase_reg == 3'd4) begin
                        low_next    = in_rdata;
                        sp_next     = sp_p1;
                        res[0].addr = {STACK_PAGE, sp_p1};
                    end else begin
                        pc_next = {in_rdata, low_reg};
                        phase_next = PH_IDLE;
                        res[0].kind = RES_DONE;
                    end
                end
                default: begin
                    // Return from subroutine
                    if (phase_reg == 3'd1) begin
                        res[0].addr = {STACK_PAGE, sp_reg};
                        sp_next     = sp_p1;
                    end else if (phase_reg == 3'd2) begin
                        res[0].addr = {STACK_PAGE, sp_reg};
                    end else if (phase_reg == 3'd3) begin
                        low_next    = in_rdata;
                        sp_next     = sp_p1;
                        res[0].addr = {STACK_PAGE, sp_p1};
                    end else if (phase_reg == 3'd4) begin
                        pc_next     = {in_rdata, low_reg};
                        res[0].addr = {in_rdata, low_reg};
                    end else begin
                        pc_next = pc_p1;
                        phase_next = PH_IDLE;
                        res[0].kind = RES_DONE;
                    end
                end
            endcase
            if (res[0].kind == RES_DONE) begin
                res[0].pc     = pc_next;
                res[0].sp     = sp_next;
                res[0].status = status_next;
            end
        end

        // Flag the last word of the burst
        for (int i = 0; i < MAX_BURST; i++) begin
            if (BURST_W'(i + 1) == n_res) begin
                res[i].last = 1'b1;
            end
        end
    end

    assign n_push = s_accept ? n_res : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            kind_reg   <= INS_JMP_ABS;
            pc_reg     <= '0;
            sp_reg     <= '0;
            status_reg <= '0;
            low_reg    <= '0;
            ptr_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                pc_reg     <= pc_next;
                sp_reg     <= sp_next;
                status_reg <= status_next;
                low_reg    <= low_next;
                ptr_reg    <= ptr_next;
            end
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(n_push);
            if (m_accept) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(m_accept);
        end
    end

    // Queue payload needs no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_BURST; i++) begin
            if (BURST_W'(i) < n_push) begin
                fifo_reg[wr_ptr_reg + FIFO_PTR_W'(i)] <= res[i];
            end
        end
    end

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // Phase stays within the longest sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= 3'd5)
        else $error("phase out of range");

    // A known instruction start always arms the first read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == OP_START && in_instr <= INS_RTS) |=> (phase_reg == 3'd1))
        else $error("start did not enter first phase");

    // A done word always closes its burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == RES_DONE) |-> m_tlast)
        else $error("done word without tlast");

    // Draining the last word with nothing pushed empties the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && count_reg == FIFO_CNT_W'(1) && n_push == '0) |=> !m_tvalid)
        else $error("queue count mismatch after drain");

endmodule

`default_nettype wire
